[hdl/mlfq_pkg.sv]
// Shared constants and codes for the multilevel feedback queue scheduler.
package mlfq_pkg;
    localparam int NUM_LEVELS = 4;
    localparam int MAX_JOBS   = 16;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int JOB_W      = $clog2(MAX_JOBS);
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_SCHED  = 2'd2;
    localparam logic [1:0] ACT_STATUS = 2'd3;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DEAD  = 2'd2;
    localparam logic [1:0] ST_CODE3 = 2'd3;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_IN_USE  = 2'd1;
    localparam logic [1:0] RC_UNKNOWN = 2'd2;
    localparam logic [1:0] RC_NONE    = 2'd3;

    localparam logic [1:0] REG_ALLOT  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_TICK   = 2'd2;

    localparam logic [15:0] ALLOT_RESET  = 16'd50;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [7:0]  TICK_RESET   = 8'd10;
endpackage

[hdl/mlfq_scheduler_core.sv]
// Multilevel feedback queue scheduler: job slots, linked level queues, sequencer.
//
//   channel  | direction | carries
//   s_axis   | in        | tuser: action[1:0]; tdata: job_id, job_is_user, job_status
//   m_axis   | out       | tdata: selected_valid, selected_job, result_code
//   apb      | in/out    | time_allotment, boost_period, tick_length
//
// A schedule request walks the queues one link per cycle on a single next-pointer
// read port; add, set-status and ticks go from idle to the response state, a boost
// tick by way of the boost state.
// aresetn is synchronous, active low; it empties every queue and frees every slot.
// s_tready is high only when the sequencer is idle; a result waiting on m_tready
// stalls the sequencer in its response state.
module mlfq_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // job_id[3:0], job_is_user[4], job_status[6:5], zero[7]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // selected_valid[0], selected_job[4:1], result_code[6:5]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mlfq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RESP  = 4'd1;
    localparam logic [3:0] S_BOOST = 4'd2;
    localparam logic [3:0] S_SCHED = 4'd3;
    localparam logic [3:0] S_RM    = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_FIX   = 4'd6;
    localparam logic [3:0] S_AFTER = 4'd7;
    localparam logic [3:0] S_CNT0  = 4'd8;
    localparam logic [3:0] S_CNTW  = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;

    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_JOBS);

    logic [15:0] allot_reg, period_reg;
    logic [7:0]  tick_reg;

    logic             used_reg  [MAX_JOBS];
    logic [LVL_W-1:0] level_reg [MAX_JOBS];
    logic [15:0]      time_reg  [MAX_JOBS];
    logic [1:0]       sstate_reg[MAX_JOBS];
    logic             user_reg  [MAX_JOBS];
    logic [JOB_W-1:0] link_reg  [MAX_JOBS];

    logic [JOB_W-1:0] head_reg [NUM_LEVELS];
    logic [JOB_W-1:0] tail_reg [NUM_LEVELS];
    logic             empty_reg[NUM_LEVELS];

    logic             run_reg;
    logic [JOB_W-1:0] run_slot_reg;
    logic [15:0]      boost_reg;

    logic [3:0]       fsm_reg;
    logic [1:0]       code_reg;
    logic             ctx_dead_reg;
    logic [JOB_W-1:0] rm_slot_reg;
    logic [LVL_W-1:0] rm_lvl_reg;
    logic [LVL_W-1:0] new_lvl_reg;
    logic [JOB_W-1:0] cur_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;

    logic [1:0]       in_action;
    logic [JOB_W-1:0] in_id;
    logic             in_user;
    logic [1:0]       in_status;
    logic [16:0]      time_sum, boost_sum;
    logic [15:0]      time_sat, boost_sat;
    logic [JOB_W-1:0] rs;
    logic             over;
    logic [JOB_W-1:0] nx;
    logic [JOB_W-1:0] hd;
    logic             s_acc, cfg_wr;

    assign in_action = s_tuser;
    assign in_id     = s_tdata[3:0];
    assign in_user   = s_tdata[4];
    assign in_status = s_tdata[6:5];

    assign s_tready = (fsm_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign rs        = run_slot_reg;
    assign time_sum  = {1'b0, time_reg[rs]} + {9'd0, tick_reg};
    assign time_sat  = time_sum[16] ? 16'hFFFF : time_sum[15:0];
    assign boost_sum = {1'b0, boost_reg} + {9'd0, tick_reg};
    assign boost_sat = boost_sum[16] ? 16'hFFFF : boost_sum[15:0];
    assign over      = time_reg[rs] > allot_reg;
    assign nx        = link_reg[cur_reg];
    assign hd        = head_reg[lvl_reg];

    always_comb begin
        unique case (paddr[3:2])
            REG_ALLOT:  prdata = {16'd0, allot_reg};
            REG_PERIOD: prdata = {16'd0, period_reg};
            REG_TICK:   prdata = {24'd0, tick_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allot_reg  <= ALLOT_RESET;
            period_reg <= PERIOD_RESET;
            tick_reg   <= TICK_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ALLOT:  allot_reg  <= pwdata[15:0];
                REG_PERIOD: period_reg <= pwdata[15:0];
                REG_TICK:   tick_reg   <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= S_IDLE;
            m_valid_reg  <= 1'b0;
            run_reg      <= 1'b0;
            run_slot_reg <= '0;
            boost_reg    <= '0;
            for (int i = 0; i < MAX_JOBS; i++) used_reg[i] <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                empty_reg[l] <= 1'b1;
            end
        end else begin
            if (m_valid_reg && m_tready && fsm_reg != S_RESP) m_valid_reg <= 1'b0;
            unique case (fsm_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        unique case (in_action)
                            ACT_ADD: begin
                                fsm_reg <= S_RESP;
                                if (used_reg[in_id]) begin
                                    code_reg <= RC_IN_USE;
                                end else begin
                                    code_reg          <= RC_OK;
                                    used_reg[in_id]   <= 1'b1;
                                    time_reg[in_id]   <= '0;
                                    sstate_reg[in_id] <= ST_READY;
                                    user_reg[in_id]   <= in_user;
                                    level_reg[in_id]  <= '0;
                                    if (empty_reg[0]) head_reg[0] <= in_id;
                                    else link_reg[tail_reg[0]] <= in_id;
                                    tail_reg[0]  <= in_id;
                                    empty_reg[0] <= 1'b0;
                                end
                            end
                            ACT_TICK: begin
                                code_reg <= RC_OK;
                                if (boost_sat > period_reg) begin
                                    // every slot back to the top level with zero time
                                    boost_reg <= '0;
                                    for (int i = 0; i < MAX_JOBS; i++) begin
                                        time_reg[i]  <= '0;
                                        level_reg[i] <= '0;
                                    end
                                    lvl_reg <= LVL_W'(1);
                                    fsm_reg <= S_BOOST;
                                end else begin
                                    boost_reg <= boost_sat;
                                    if (run_reg) time_reg[rs] <= time_sat;
                                    fsm_reg <= S_RESP;
                                end
                            end
                            ACT_SCHED: begin
                                code_reg <= RC_OK;
                                fsm_reg  <= S_SCHED;
                            end
                            default: begin
                                fsm_reg <= S_RESP;
                                if (!used_reg[in_id]) begin
                                    code_reg <= RC_UNKNOWN;
                                end else begin
                                    code_reg <= RC_OK;
                                    sstate_reg[in_id] <=
                                        (in_status == ST_CODE3) ? ST_WAIT : in_status;
                                end
                            end
                        endcase
                    end
                end
                S_BOOST: begin
                    // splice the whole level onto the tail of level 0
                    if (!empty_reg[lvl_reg]) begin
                        if (empty_reg[0]) head_reg[0] <= hd;
                        else link_reg[tail_reg[0]] <= hd;
                        tail_reg[0]        <= tail_reg[lvl_reg];
                        empty_reg[0]       <= 1'b0;
                        empty_reg[lvl_reg] <= 1'b1;
                    end
                    lvl_reg <= lvl_reg + 1'b1;
                    if (lvl_reg == LVL_LAST) fsm_reg <= S_RESP;
                end
                S_SCHED: begin
                    if (run_reg && sstate_reg[rs] == ST_READY && !over) begin
                        fsm_reg <= S_RESP;
                    end else begin
                        run_reg      <= 1'b0;
                        run_slot_reg <= '0;
                        lvl_reg      <= '0;
                        rm_slot_reg  <= rs;
                        rm_lvl_reg   <= level_reg[rs];
                        ctx_dead_reg <= (sstate_reg[rs] == ST_DEAD);
                        new_lvl_reg  <= (user_reg[rs] && level_reg[rs] != LVL_LAST)
                                        ? level_reg[rs] + 1'b1 : level_reg[rs];
                        if (run_reg && sstate_reg[rs] == ST_DEAD) begin
                            fsm_reg <= S_RM;
                        end else if (run_reg && over) begin
                            sstate_reg[rs] <= ST_READY;
                            time_reg[rs]   <= '0;
                            fsm_reg        <= S_RM;
                        end else begin
                            fsm_reg <= S_CNT0;
                        end
                    end
                end
                S_RM: begin
                    if (empty_reg[rm_lvl_reg]) begin
                        fsm_reg <= S_AFTER;
                    end else if (head_reg[rm_lvl_reg] == rm_slot_reg) begin
                        if (tail_reg[rm_lvl_reg] == rm_slot_reg) empty_reg[rm_lvl_reg] <= 1'b1;
                        else head_reg[rm_lvl_reg] <= link_reg[rm_slot_reg];
                        fsm_reg <= S_AFTER;
                    end else begin
                        cur_reg <= head_reg[rm_lvl_reg];
                        cnt_reg <= '0;
                        fsm_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (cnt_reg < CNT_MAX && cur_reg != tail_reg[rm_lvl_reg]) begin
                        if (nx == rm_slot_reg) begin
                            if (tail_reg[rm_lvl_reg] == rm_slot_reg) begin
                                tail_reg[rm_lvl_reg] <= cur_reg;
                                fsm_reg <= S_AFTER;
                            end else begin
                                fsm_reg <= S_FIX;
                            end
                        end else begin
                            cur_reg <= nx;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end else begin
                        fsm_reg <= S_AFTER;
                    end
                end
                S_FIX: begin
                    link_reg[cur_reg] <= link_reg[rm_slot_reg];
                    fsm_reg <= S_AFTER;
                end
                S_AFTER: begin
                    if (ctx_dead_reg) begin
                        used_reg[rm_slot_reg] <= 1'b0;
                    end else begin
                        level_reg[rm_slot_reg] <= new_lvl_reg;
                        if (empty_reg[new_lvl_reg]) head_reg[new_lvl_reg] <= rm_slot_reg;
                        else link_reg[tail_reg[new_lvl_reg]] <= rm_slot_reg;
                        tail_reg[new_lvl_reg]  <= rm_slot_reg;
                        empty_reg[new_lvl_reg] <= 1'b0;
                    end
                    fsm_reg <= S_CNT0;
                end
                S_CNT0: begin
                    if (empty_reg[lvl_reg]) begin
                        cnt_reg <= '0;
                        fsm_reg <= S_SCAN;
                    end else begin
                        cur_reg <= hd;
                        cnt_reg <= CNT_W'(1);
                        fsm_reg <= S_CNTW;
                    end
                end
                S_CNTW: begin
                    if (cnt_reg < CNT_MAX && cur_reg != tail_reg[lvl_reg]) begin
                        cur_reg <= nx;
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        fsm_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cnt_reg != '0 && !empty_reg[lvl_reg]) begin
                        if (sstate_reg[hd] == ST_READY) begin
                            run_reg      <= 1'b1;
                            run_slot_reg <= hd;
                            fsm_reg      <= S_RESP;
                        end else begin
                            // drop dead heads, rotate waiting heads to the tail
                            cnt_reg <= cnt_reg - 1'b1;
                            if (sstate_reg[hd] == ST_DEAD) begin
                                used_reg[hd] <= 1'b0;
                                if (tail_reg[lvl_reg] == hd) empty_reg[lvl_reg] <= 1'b1;
                                else head_reg[lvl_reg] <= link_reg[hd];
                            end else if (tail_reg[lvl_reg] != hd) begin
                                head_reg[lvl_reg]           <= link_reg[hd];
                                link_reg[tail_reg[lvl_reg]] <= hd;
                                tail_reg[lvl_reg]           <= hd;
                            end
                        end
                    end else if (lvl_reg == LVL_LAST) begin
                        fsm_reg <= S_RESP;
                    end else begin
                        lvl_reg <= lvl_reg + 1'b1;
                        fsm_reg <= S_CNT0;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, code_reg, run_reg ? run_slot_reg : 4'd0, run_reg};
                        fsm_reg     <= S_IDLE;
                    end
                end
                default: fsm_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/mlfq_checker.sv]
// Port-level assertions for the scheduler core and their bind.
module mlfq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       pready
);
    import mlfq_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:5] != RC_NONE)
        else $error("undefined result code");

    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("job shown with no selection");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");
endmodule

bind mlfq_scheduler_core mlfq_checker u_mlfq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
